@@ hw/rtl/skl_pkg.sv @@
// Shared types and constants for the stepped keyframe lookup unit.
`timescale 1ns / 1ps

package skl_pkg;

  localparam int LEN_W     = 15;
  localparam int VAL_W     = 16;
  localparam int TIME_W    = 32;
  localparam int FPS_W     = 8;
  localparam int KIND_W    = 2;
  localparam int FRAME_W   = TIME_W + FPS_W - 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;

  localparam logic [FPS_W-1:0] FPS_RESET = 8'd12;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FPS       = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_PRIME,
    ST_WALK,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic accept;
    logic do_mul;
    logic mod_step;
    logic walk_init;
    logic walk_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic loop_mode;
    logic mod_last;
    logic walk_hit;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/skl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module skl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/skl_ctrl.sv @@
// Sequencer for table updates and the multiply, modulo and walk steps of a query.
`timescale 1ns / 1ps

module skl_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic [skl_pkg::KIND_W-1:0] in_kind,
  output logic                       in_tready,
  input  skl_pkg::status_t           status,
  output skl_pkg::cmd_t              cmd
);

  skl_pkg::state_t state_r, state_nxt;
  logic accept;

  assign accept = in_tvalid && (state_r == skl_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skl_pkg::ST_IDLE: begin
        if (accept && (in_kind == skl_pkg::KIND_QUERY)) begin
          state_nxt = skl_pkg::ST_MUL;
        end
      end
      skl_pkg::ST_MUL: begin
        if (status.empty) begin
          state_nxt = skl_pkg::ST_HOLD;
        end else if (status.loop_mode) begin
          state_nxt = skl_pkg::ST_MOD;
        end else begin
          state_nxt = skl_pkg::ST_PRIME;
        end
      end
      skl_pkg::ST_MOD: begin
        if (status.mod_last) begin
          state_nxt = skl_pkg::ST_PRIME;
        end
      end
      skl_pkg::ST_PRIME: begin
        state_nxt = skl_pkg::ST_WALK;
      end
      skl_pkg::ST_WALK: begin
        if (status.walk_hit) begin
          state_nxt = skl_pkg::ST_HOLD;
        end
      end
      skl_pkg::ST_HOLD: begin
        if (status.out_free) begin
          state_nxt = skl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = skl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      skl_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.accept = accept;
      end
      skl_pkg::ST_MUL:   cmd.do_mul = 1'b1;
      skl_pkg::ST_MOD:   cmd.mod_step = 1'b1;
      skl_pkg::ST_PRIME: cmd.walk_init = 1'b1;
      skl_pkg::ST_WALK:  cmd.walk_step = 1'b1;
      skl_pkg::ST_HOLD:  cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hw/rtl/skl_datapath.sv @@
// Keyframe table, frame arithmetic, span walk and result register.
`timescale 1ns / 1ps

module skl_datapath #(
  parameter int MAX_KEYFRAMES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [skl_pkg::KIND_W-1:0]    in_kind,
  input  logic [skl_pkg::LEN_W-1:0]     in_length,
  input  logic signed [skl_pkg::VAL_W-1:0] in_value,
  input  logic [skl_pkg::TIME_W-1:0]    in_time,
  input  logic                          cfg_we,
  input  logic [skl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [skl_pkg::CFG_W-1:0]     cfg_wdata,
  input  skl_pkg::cmd_t                 cmd,
  output skl_pkg::status_t              status,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic signed [skl_pkg::VAL_W-1:0] out_value,
  output logic                          out_table_ready
);

  localparam int CNT_W = $clog2(MAX_KEYFRAMES + 1);
  localparam int IDX_W = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
  localparam int TOT_W = $clog2(MAX_KEYFRAMES * 32767 + 1);
  localparam int CMP_W = (TOT_W > skl_pkg::FRAME_W) ? TOT_W : skl_pkg::FRAME_W;
  localparam int MCNT_W = $clog2(skl_pkg::FRAME_W);
  localparam int ENT_W = skl_pkg::LEN_W + skl_pkg::VAL_W;
  localparam int PROD_W = skl_pkg::TIME_W + skl_pkg::FPS_W;

  logic                          loop_r;
  logic [skl_pkg::FPS_W-1:0]     fps_r;
  logic [CNT_W-1:0]              count_r;
  logic [TOT_W-1:0]              total_r;
  logic [skl_pkg::TIME_W-1:0]    time_r;
  logic [skl_pkg::FRAME_W-1:0]   frame_r;
  logic [TOT_W-1:0]              rem_r;
  logic [MCNT_W-1:0]             mcnt_r;
  logic [IDX_W-1:0]              idx_r;
  logic [TOT_W-1:0]              end_r;
  logic signed [skl_pkg::VAL_W-1:0] res_val_r;
  logic                          out_valid_r;
  logic signed [skl_pkg::VAL_W-1:0] out_val_r;
  logic                          out_ready_r;

  logic                          do_add, do_clear, full;
  logic [PROD_W-1:0]             product;
  logic [TOT_W:0]                rem_shift;
  logic [TOT_W:0]                rem_diff;
  logic [TOT_W-1:0]              rem_nxt;
  logic [TOT_W-1:0]              end_sum;
  logic [IDX_W-1:0]              raddr;
  logic [ENT_W-1:0]              rdata;
  logic [skl_pkg::LEN_W-1:0]     rd_len;
  logic                          is_last, in_span;

  assign full     = (count_r == CNT_W'(MAX_KEYFRAMES));
  assign do_clear = cmd.accept && (in_kind == skl_pkg::KIND_CLEAR);
  assign do_add   = cmd.accept && (in_kind == skl_pkg::KIND_ADD) &&
                    (in_length != '0) && !full;

  skl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_KEYFRAMES),
    .ADDR_W(IDX_W)
  ) u_table (
    .clk  (clk),
    .we   (do_add),
    .waddr(count_r[IDX_W-1:0]),
    .wdata({in_value, in_length}),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Entry k is on the read port while the address of entry k+1 is presented.
  assign raddr   = cmd.walk_init ? '0 : IDX_W'(idx_r + 1'b1);
  assign rd_len  = rdata[skl_pkg::LEN_W-1:0];
  assign end_sum = end_r + TOT_W'(rd_len);
  assign is_last = (CNT_W'(idx_r) == CNT_W'(count_r - 1'b1));
  assign in_span = (CMP_W'(frame_r) < CMP_W'(end_sum));

  assign product = PROD_W'(time_r) * PROD_W'(fps_r);

  // One restoring step of frame mod total, most significant frame bit first.
  assign rem_shift = {rem_r, frame_r[skl_pkg::FRAME_W-1]};
  assign rem_diff  = rem_shift - {1'b0, total_r};
  assign rem_nxt   = rem_diff[TOT_W] ? rem_shift[TOT_W-1:0] : rem_diff[TOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_r      <= 1'b0;
      fps_r       <= skl_pkg::FPS_RESET;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          skl_pkg::CFG_LOOP_MODE: loop_r <= cfg_wdata[0];
          skl_pkg::CFG_FPS:       fps_r  <= cfg_wdata[skl_pkg::FPS_W-1:0];
          default: ;
        endcase
      end
      if (do_clear) begin
        count_r <= '0;
        total_r <= '0;
      end else if (do_add) begin
        count_r <= count_r + 1'b1;
        total_r <= total_r + TOT_W'(in_length);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      time_r <= in_time;
    end
    if (cmd.do_mul) begin
      frame_r <= product[PROD_W-1:16];
      rem_r   <= '0;
      mcnt_r  <= '0;
    end else if (cmd.mod_step) begin
      rem_r  <= rem_nxt;
      mcnt_r <= mcnt_r + 1'b1;
      if (mcnt_r == MCNT_W'(skl_pkg::FRAME_W - 1)) begin
        // The remainder never exceeds the frame, so it fits the frame register.
        frame_r <= skl_pkg::FRAME_W'(rem_nxt);
      end else begin
        frame_r <= {frame_r[skl_pkg::FRAME_W-2:0], 1'b0};
      end
    end
    if (cmd.walk_init) begin
      idx_r <= '0;
      end_r <= '0;
    end else if (cmd.walk_step) begin
      idx_r <= IDX_W'(idx_r + 1'b1);
      end_r <= end_sum;
      res_val_r <= rdata[ENT_W-1:skl_pkg::LEN_W];
    end
    if (cmd.out_load) begin
      out_val_r   <= (count_r == '0) ? '0 : res_val_r;
      out_ready_r <= (count_r != '0);
    end
  end

  always_comb begin
    status.empty     = (count_r == '0);
    status.loop_mode = loop_r;
    status.mod_last  = (mcnt_r == MCNT_W'(skl_pkg::FRAME_W - 1));
    status.walk_hit  = in_span || is_last;
    status.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid      = out_valid_r;
  assign out_value       = out_val_r;
  assign out_table_ready = out_ready_r;

endmodule

@@ hw/rtl/stepped_keyframe_lookup_unit.sv @@
// Top level of the stepped keyframe lookup unit.
`timescale 1ns / 1ps

// Step keyframe track: clear and append items are accepted on back-to-back
// cycles. A query is accepted, multiplies time by rate, in loop mode reduces
// the frame bit-serially modulo the frame total, primes the table RAM read,
// walks the stored keyframes (at most MAX_KEYFRAMES) through its single read
// port, and loads the output register; an empty table skips from the multiply
// straight to the output load. The block takes no new item while
// a query is in progress; a finished result waits in the output register
// while the next clear or append is taken.
module stepped_keyframe_lookup_unit #(
  parameter int MAX_KEYFRAMES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // keyframe_length[14:0], keyframe_value[30:15],
                                  // query_time[62:31], zero [63]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // sample_value[15:0]
  output logic        out_tuser,  // table_ready[0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  skl_pkg::cmd_t    cmd;
  skl_pkg::status_t status;
  logic signed [skl_pkg::VAL_W-1:0] out_value;

  skl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_kind  (in_tuser),
    .in_tready(in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  skl_datapath #(
    .MAX_KEYFRAMES(MAX_KEYFRAMES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_kind        (in_tuser),
    .in_length      (in_tdata[14:0]),
    .in_value       (in_tdata[30:15]),
    .in_time        (in_tdata[62:31]),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .status         (status),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_value      (out_value),
    .out_table_ready(out_tuser)
  );

  assign out_tdata = out_value;

endmodule

@@ sim/stepped_keyframe_lookup_unit_tb.sv @@
// Self-checking testbench for the stepped keyframe lookup unit.
`timescale 1ns / 1ps

module stepped_keyframe_lookup_unit_tb;

  localparam int MAX_KEYS     = 64;
  localparam int SETTLE       = 100;
  localparam int HOLD_CYCLES  = 500;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [skl_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [skl_pkg::TIME_W-1:0] TIME_MAX    = 32'hFFFF_FFFF;

  typedef logic [skl_pkg::KIND_W-1:0] kind_t;
  typedef logic [skl_pkg::LEN_W-1:0]  len_t;
  typedef logic [skl_pkg::VAL_W-1:0]  val_t;
  typedef logic [skl_pkg::CFG_W-1:0]  cfg_data_t;

  typedef struct {
    logic [skl_pkg::KIND_W-1:0]       kind;
    logic [skl_pkg::LEN_W-1:0]        span_len;
    logic signed [skl_pkg::VAL_W-1:0] span_val;
    logic [skl_pkg::TIME_W-1:0]       at_time;
  } track_item_t;

  typedef struct {
    logic signed [skl_pkg::VAL_W-1:0] sample;
    logic                             ready;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  stepped_keyframe_lookup_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow of the track as the block should hold it.
  logic [skl_pkg::LEN_W-1:0]        key_lens [MAX_KEYS];
  logic signed [skl_pkg::VAL_W-1:0] key_vals [MAX_KEYS];
  int unsigned                      key_count = 0;
  longint unsigned                  key_total = 0;
  logic                             cfg_loop = 1'b0;
  logic [skl_pkg::FPS_W-1:0]        cfg_fps = skl_pkg::FPS_RESET;

  track_item_t     pending_items [$];
  sample_t         expected_samples [$];
  track_item_t     drive_item;
  bit              in_taken = 0;
  int              idle_pct = 35;
  bit              hold_on = 0;
  event            hold_start;
  int              mismatch_count = 0;
  int              cycle_count = 0;

  // Stimulus planning: cumulative span ends of the table as it will be built.
  longint unsigned plan_ends [$];
  longint unsigned plan_total = 0;
  int              queued_count = 0;

  task automatic track_step(input track_item_t it);
    longint unsigned                  frame;
    longint unsigned                  span_end;
    logic signed [skl_pkg::VAL_W-1:0] found;
    bit                               hit;
    case (it.kind)
      skl_pkg::KIND_CLEAR: begin
        key_count = 0;
        key_total = 0;
      end
      skl_pkg::KIND_ADD: begin
        if (it.span_len != 0 && key_count < MAX_KEYS) begin
          key_lens[key_count] = it.span_len;
          key_vals[key_count] = it.span_val;
          key_count++;
          key_total += it.span_len;
        end
      end
      skl_pkg::KIND_QUERY: begin
        if (key_count == 0 || key_total == 0) begin
          expected_samples.push_back('{sample: '0, ready: 1'b0});
        end else begin
          frame = (longint'(it.at_time) * longint'(cfg_fps)) >> 16;
          if (cfg_loop)
            frame = frame % key_total;
          found = key_vals[key_count-1];
          span_end = 0;
          hit = 0;
          for (int i = 0; i < key_count; i++) begin
            span_end += key_lens[i];
            if (!hit && frame < span_end) begin
              found = key_vals[i];
              hit = 1;
            end
          end
          expected_samples.push_back('{sample: found, ready: 1'b1});
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_item(input logic [skl_pkg::KIND_W-1:0] kind,
                           input logic [skl_pkg::LEN_W-1:0] len,
                           input logic [skl_pkg::VAL_W-1:0] val,
                           input logic [skl_pkg::TIME_W-1:0] t);
    track_item_t it;
    it.kind = kind;
    it.span_len = len;
    it.span_val = val;
    it.at_time = t;
    pending_items.push_back(it);
    if (kind == skl_pkg::KIND_CLEAR) begin
      plan_ends.delete();
      plan_total = 0;
    end else if (kind == skl_pkg::KIND_ADD && len != 0 && plan_ends.size() < MAX_KEYS) begin
      plan_total += len;
      plan_ends.push_back(plan_total);
    end
    if (kind != KIND_UNUSED)
      queued_count++;
  endtask

  // Earliest query time that maps to the given frame at the current rate.
  function automatic logic [skl_pkg::TIME_W-1:0] time_for_frame(input longint unsigned f);
    longint unsigned t;
    if (cfg_fps == 0)
      return $urandom();
    t = (f * 65536 + cfg_fps - 1) / cfg_fps;
    if (t > TIME_MAX)
      return TIME_MAX;
    return t[skl_pkg::TIME_W-1:0];
  endfunction

  function automatic logic [skl_pkg::TIME_W-1:0] pick_query_time();
    int              r;
    longint unsigned f;
    r = $urandom_range(0, 99);
    if (plan_ends.size() == 0 || r >= 90)
      return ($urandom_range(0, 1) == 1) ? TIME_MAX : $urandom();
    if (r < 35) begin
      f = plan_ends[$urandom_range(0, plan_ends.size() - 1)];
      if (f > 0 && $urandom_range(0, 1) == 1)
        f = f - 1;
      if (cfg_loop)
        f += plan_total * $urandom_range(0, 3);
      return time_for_frame(f);
    end
    if (r < 55)
      return time_for_frame(plan_total + $urandom_range(0, 40));
    if (r < 80)
      return $urandom();
    return $urandom_range(0, 65535);
  endfunction

  // Mostly well-formed runs: optional clear, a batch of appends, then queries.
  task automatic queue_random(input int target, input bit start_full);
    int  n_adds;
    int  n_queries;
    int  r;
    bit  force_full;
    logic [skl_pkg::LEN_W-1:0] len;
    force_full = start_full;
    target += queued_count;
    while (queued_count < target) begin
      if ($urandom_range(0, 99) < 85) begin
        if (force_full || $urandom_range(0, 99) < 70)
          push_item(skl_pkg::KIND_CLEAR, len_t'($urandom()), val_t'($urandom()), $urandom());
        r = $urandom_range(0, 99);
        if (force_full)
          n_adds = 70;
        else if (r < 60)
          n_adds = $urandom_range(1, 6);
        else if (r < 85)
          n_adds = $urandom_range(7, 30);
        else
          n_adds = $urandom_range(55, 70);
        force_full = 0;
        for (int i = 0; i < n_adds; i++) begin
          r = $urandom_range(0, 99);
          if (r < 5)
            len = '0;
          else if (r < 60)
            len = len_t'($urandom_range(1, 20));
          else
            len = len_t'($urandom());
          push_item(skl_pkg::KIND_ADD, len, val_t'($urandom()), $urandom());
        end
        n_queries = $urandom_range(1, 8);
        for (int i = 0; i < n_queries; i++)
          push_item(skl_pkg::KIND_QUERY, len_t'($urandom()), val_t'($urandom()),
                    pick_query_time());
      end else begin
        push_item(kind_t'($urandom_range(0, 3)), len_t'($urandom()), val_t'($urandom()),
                  $urandom());
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [skl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [skl_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == skl_pkg::CFG_LOOP_MODE)
      cfg_loop = data[0];
    else
      cfg_fps = data;
  endtask

  // Sender: holds an item until it is taken, then may idle before the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      in_taken = 0;
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        drive_item = pending_items.pop_front();
        in_tdata <= {1'b0, drive_item.at_time, drive_item.span_val, drive_item.span_len};
        in_tuser <= drive_item.kind;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver readiness, forced low for the whole hold-off window.
  always @(negedge clk) begin
    if (!rst_n || hold_on)
      out_tready <= 1'b0;
    else
      out_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  always begin
    @(hold_start);
    hold_on = 1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 0;
  end

  always @(posedge clk) begin
    sample_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stepped_keyframe_lookup_unit regression: fail");
      $finish;
    end else if (rst_n) begin
      if (in_tvalid && in_tready) begin
        track_step(drive_item);
        in_taken = 1;
      end
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result, sample_value %0d table_ready %0b",
                   $time, $signed(out_tdata), out_tuser);
          mismatch_count++;
        end else begin
          want = expected_samples.pop_front();
          if ($signed(out_tdata) !== want.sample) begin
            $display("%0t: sample_value expected %0d, actual %0d",
                     $time, want.sample, $signed(out_tdata));
            mismatch_count++;
          end
          if (out_tuser !== want.ready) begin
            $display("%0t: table_ready expected %0b, actual %0b",
                     $time, want.ready, out_tuser);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed checks at the reset rate: empty table, rejected append, extreme
    // fields, and frames that land exactly on span boundaries.
    push_item(skl_pkg::KIND_QUERY, '0, '0, '0);
    push_item(skl_pkg::KIND_ADD, '0, 16'sd7, '0);
    push_item(skl_pkg::KIND_QUERY, '0, '0, TIME_MAX);
    push_item(skl_pkg::KIND_ADD, 15'd1, 16'h8000, '0);
    push_item(skl_pkg::KIND_ADD, 15'h7FFF, 16'h7FFF, TIME_MAX);
    push_item(skl_pkg::KIND_ADD, 15'd2, 16'h1234, '0);
    push_item(skl_pkg::KIND_QUERY, '1, '1, '0);
    push_item(skl_pkg::KIND_QUERY, '0, '0, time_for_frame(1));
    push_item(skl_pkg::KIND_QUERY, '0, '0, time_for_frame(1) - 1);
    push_item(skl_pkg::KIND_QUERY, '0, '0, time_for_frame(32768));
    push_item(skl_pkg::KIND_QUERY, '0, '0, time_for_frame(32770));
    push_item(skl_pkg::KIND_QUERY, '0, '0, TIME_MAX);
    push_item(KIND_UNUSED, '1, '1, '1);
    push_item(skl_pkg::KIND_QUERY, '0, '0, time_for_frame(32769));
    drain();

    write_reg(skl_pkg::CFG_LOOP_MODE, 8'd1);
    write_reg(skl_pkg::CFG_FPS, 8'd255);
    push_item(skl_pkg::KIND_QUERY, '0, '0, time_for_frame(32770));
    push_item(skl_pkg::KIND_QUERY, '0, '0, time_for_frame(32771));
    push_item(skl_pkg::KIND_QUERY, '0, '0, TIME_MAX);
    push_item(skl_pkg::KIND_CLEAR, '1, '1, '1);
    push_item(skl_pkg::KIND_QUERY, '0, '0, TIME_MAX);
    queue_random(250, 1);
    drain();

    write_reg(skl_pkg::CFG_LOOP_MODE, 8'd0);
    write_reg(skl_pkg::CFG_FPS, 8'd1);
    queue_random(250, 0);
    drain();

    // A zero rate maps every query to the first frame.
    write_reg(skl_pkg::CFG_LOOP_MODE, 8'd1);
    write_reg(skl_pkg::CFG_FPS, 8'd0);
    queue_random(60, 0);
    drain();

    idle_pct = 0;
    write_reg(skl_pkg::CFG_FPS, cfg_data_t'($urandom_range(1, 255)));
    queue_random(250, 0);
    drain();

    idle_pct = 35;
    write_reg(skl_pkg::CFG_LOOP_MODE, 8'd0);
    write_reg(skl_pkg::CFG_FPS, cfg_data_t'($urandom_range(1, 255)));
    queue_random(200, 0);
    -> hold_start;
    drain();

    write_reg(skl_pkg::CFG_LOOP_MODE, 8'd1);
    write_reg(skl_pkg::CFG_FPS, 8'd1);
    queue_random(140, 0);
    drain();

    if (mismatch_count == 0 && expected_samples.size() == 0)
      $display("stepped_keyframe_lookup_unit regression: pass");
    else
      $display("stepped_keyframe_lookup_unit regression: fail");
    $finish;
  end

endmodule

@@ stepped_keyframe_lookup_unit.f @@
hw/rtl/skl_pkg.sv
hw/rtl/skl_ram.sv
hw/rtl/skl_ctrl.sv
hw/rtl/skl_datapath.sv
hw/rtl/stepped_keyframe_lookup_unit.sv
sim/stepped_keyframe_lookup_unit_tb.sv
